// File: design/lsra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_pkg
// Types and default constants shared by the linear-scan register assigner.
// ----------------------------------------------------------------------------
package lsra_pkg;

	localparam int NumRegsDefault        = 6;
	localparam int CallerSavedDefault    = 2;
	localparam int PosWidthDefault       = 16;

	localparam int TempWidth   = 16;
	localparam int PortPosWidth = 16;
	localparam int RegIdxWidth = 3;

	typedef struct packed {
		logic                    new_function;
		logic [TempWidth-1:0]    temp_id;
		logic [PortPosWidth-1:0] interval_start;
		logic [PortPosWidth-1:0] interval_end;
		logic                    spans_call;
	} item_t;

	typedef struct packed {
		logic                   assigned;
		logic [RegIdxWidth-1:0] reg_index;
		logic                   evicted;
		logic [TempWidth-1:0]   evicted_temp;
	} result_t;

	// Handshake between the input register and the result register.
	typedef struct packed {
		logic valid;
		logic fire;
	} stage_ctl_t;

endpackage

// File: design/lsra_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_chan_if
// Valid/ready channel carrying one payload word per transaction.
// ----------------------------------------------------------------------------
interface lsra_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: design/linear_scan_register_assigner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_scan_register_assigner
// Assigns machine registers to live intervals presented in start order.
// ----------------------------------------------------------------------------
// The block accepts one interval per clock cycle while the result register
// can load, and returns one result per interval, in order. An accepted
// interval sits in the input register while a single pass through the slot
// compare, victim search and priority encode computes the decision, and the
// edge that moves it on writes both the active slot file and the result
// register. The slot file is updated in that same pass, so back-to-back
// intervals see each other's assignments. A stalled result register holds
// the input side only once the input register is full.
module linear_scan_register_assigner #(
	parameter int NUM_REGS           = lsra_pkg::NumRegsDefault,
	parameter int CALLER_SAVED_COUNT = lsra_pkg::CallerSavedDefault,
	parameter int POS_WIDTH          = lsra_pkg::PosWidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	lsra_chan_if.sink   items,
	lsra_chan_if.source results
);
	import lsra_pkg::*;

	stage_ctl_t ctl;
	item_t      item_s1;
	result_t    result;
	logic       can_load;

	lsra_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.can_load (can_load),
		.ctl      (ctl),
		.item_s1  (item_s1)
	);

	lsra_alloc #(
		.NUM_REGS           (NUM_REGS),
		.CALLER_SAVED_COUNT (CALLER_SAVED_COUNT),
		.POS_WIDTH          (POS_WIDTH)
	) u_alloc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.item_s1 (item_s1),
		.result  (result)
	);

	lsra_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.result   (result),
		.can_load (can_load),
		.results  (results)
	);
endmodule

// File: design/lsra_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_in_stage
// Input register: holds one interval until the assignment pass consumes it.
// ----------------------------------------------------------------------------
module lsra_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	lsra_chan_if.sink          items,
	input  logic               can_load,
	output lsra_pkg::stage_ctl_t ctl,
	output lsra_pkg::item_t    item_s1
);
	import lsra_pkg::*;

	logic valid_s1;
	logic fire;

	assign fire        = valid_s1 && can_load;
	assign items.ready = !valid_s1 || can_load;
	assign ctl.valid   = valid_s1;
	assign ctl.fire    = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.data;
		end
	end
endmodule

// File: design/lsra_alloc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_alloc
// Active slot file and the single-pass decision: expire, pick, evict or spill.
// ----------------------------------------------------------------------------
module lsra_alloc #(
	parameter int NUM_REGS           = lsra_pkg::NumRegsDefault,
	parameter int CALLER_SAVED_COUNT = lsra_pkg::CallerSavedDefault,
	parameter int POS_WIDTH          = lsra_pkg::PosWidthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsra_pkg::stage_ctl_t ctl,
	input  lsra_pkg::item_t      item_s1,
	output lsra_pkg::result_t    result
);
	import lsra_pkg::*;

	localparam int IdxW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int Split = (CALLER_SAVED_COUNT < NUM_REGS) ? CALLER_SAVED_COUNT : NUM_REGS;

	logic [NUM_REGS-1:0]  busy_q;
	logic [POS_WIDTH-1:0] end_q  [NUM_REGS];
	logic [TempWidth-1:0] temp_q [NUM_REGS];

	logic [31:0]          start_ext, end_ext;
	logic [POS_WIDTH-1:0] start_pos, end_pos;
	logic [NUM_REGS-1:0]  caller_mask, free_v, pref_v, alt_v, victim_oh;
	logic [NUM_REGS-1:0]  busy_next;
	logic                 any_pref, any_alt, any_free, evict, take;
	logic [IdxW-1:0]      pref_idx, alt_idx, victim_idx, pick_idx;
	logic [POS_WIDTH-1:0] victim_end;
	logic [TempWidth-1:0] victim_temp;
	logic [31:0]          pick_ext;

	function automatic logic [IdxW-1:0] lowest(input logic [NUM_REGS-1:0] v);
		logic [IdxW-1:0] idx;
		idx = '0;
		for (int i = NUM_REGS - 1; i >= 0; i--) begin
			if (v[i]) idx = IdxW'(i);
		end
		return idx;
	endfunction

	// Positions are reduced to the stored width.
	assign start_ext = 32'(item_s1.interval_start);
	assign end_ext   = 32'(item_s1.interval_end);
	assign start_pos = start_ext[POS_WIDTH-1:0];
	assign end_pos   = end_ext[POS_WIDTH-1:0];

	always_comb begin
		for (int r = 0; r < NUM_REGS; r++) begin
			caller_mask[r] = (r < Split);
			free_v[r] = item_s1.new_function || !busy_q[r] || (end_q[r] < start_pos);
		end
	end

	assign pref_v   = item_s1.spans_call ? (free_v & ~caller_mask) : (free_v & caller_mask);
	assign alt_v    = item_s1.spans_call ? (free_v & caller_mask) : (free_v & ~caller_mask);
	assign any_pref = |pref_v;
	assign any_alt  = |alt_v;
	assign any_free = any_pref || any_alt;
	assign pref_idx = lowest(pref_v);
	assign alt_idx  = lowest(alt_v);

	// A slot is the victim when its end beats every lower slot strictly and
	// every higher slot or ties it, so a tie goes to the lowest index.
	always_comb begin
		for (int r = 0; r < NUM_REGS; r++) begin
			victim_oh[r] = 1'b1;
			for (int k = 0; k < NUM_REGS; k++) begin
				if (k < r && !(end_q[r] > end_q[k])) victim_oh[r] = 1'b0;
				if (k > r && !(end_q[r] >= end_q[k])) victim_oh[r] = 1'b0;
			end
		end
	end

	always_comb begin
		victim_idx  = '0;
		victim_end  = '0;
		victim_temp = '0;
		for (int r = 0; r < NUM_REGS; r++) begin
			if (victim_oh[r]) begin
				victim_idx  = victim_idx | IdxW'(r);
				victim_end  = victim_end | end_q[r];
				victim_temp = victim_temp | temp_q[r];
			end
		end
	end

	assign evict    = !any_free && (victim_end > end_pos);
	assign take     = any_free || evict;
	assign pick_idx = any_pref ? pref_idx : (any_alt ? alt_idx : victim_idx);
	assign pick_ext = 32'(pick_idx);

	assign result.assigned     = take;
	assign result.reg_index    = take ? pick_ext[RegIdxWidth-1:0] : '0;
	assign result.evicted      = evict;
	assign result.evicted_temp = evict ? victim_temp : '0;

	always_comb begin
		busy_next = ~free_v;
		if (take) busy_next[pick_idx] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (ctl.fire) begin
			busy_q <= busy_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && take) begin
			end_q[pick_idx]  <= end_pos;
			temp_q[pick_idx] <= item_s1.temp_id;
		end
	end
endmodule

// File: design/lsra_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module lsra_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsra_pkg::stage_ctl_t ctl,
	input  lsra_pkg::result_t    result,
	output logic                 can_load,
	lsra_chan_if.source          results
);
	import lsra_pkg::*;

	logic    valid_q;
	result_t result_q;

	assign can_load      = !valid_q || results.ready;
	assign results.valid = valid_q;
	assign results.data  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			result_q <= result;
		end
	end
endmodule
